// ===== sv/efg_pkg.sv =====
// Package for the event flag group unit: sizes, operation and status codes,
// controller states and the flag-condition helper. Depends on nothing.
package efg_pkg;

  localparam int unsigned GROUPS    = 8;
  localparam int unsigned WAITERS   = 16;
  localparam int unsigned FLAG_BITS = 32;
  localparam int unsigned GW        = 3;
  localparam int unsigned WW        = 4;

  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_PEND   = 2'd1,
    MODE_POST   = 2'd2,
    MODE_CANCEL = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PARKED    = 3'd1,
    ST_POOL      = 3'd2,
    ST_NOT_LIVE  = 3'd3,
    ST_CANCELLED = 3'd4,
    ST_WOKEN     = 3'd5,
    ST_BAD_WAIT  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAKE,
    S_FINAL,
    S_RESP
  } state_e;

  localparam logic [1:0] KIND_ALL_CLR = 2'd0;
  localparam logic [1:0] KIND_ANY_CLR = 2'd1;
  localparam logic [1:0] KIND_ALL_SET = 2'd2;
  localparam logic [1:0] KIND_ANY_SET = 2'd3;

  // Satisfying bits of a condition; kinds below all-set look at clear bits.
  function automatic logic [FLAG_BITS-1:0] ready_bits(input logic [FLAG_BITS-1:0] cur,
                                                      input logic [FLAG_BITS-1:0] want,
                                                      input logic [1:0] kind);
    ready_bits = kind[1] ? (want & cur) : (want & ~cur);
  endfunction

  function automatic logic cond_met(input logic [FLAG_BITS-1:0] want,
                                    input logic [FLAG_BITS-1:0] rdy,
                                    input logic [1:0] kind);
    cond_met = kind[0] ? (rdy != '0) : (rdy == want);
  endfunction

  function automatic logic [FLAG_BITS-1:0] consume_bits(input logic [FLAG_BITS-1:0] cur,
                                                        input logic [FLAG_BITS-1:0] rdy,
                                                        input logic [1:0] kind);
    consume_bits = kind[1] ? (cur & ~rdy) : (cur | rdy);
  endfunction

endpackage

// ===== sv/event_flag_group_unit.sv =====
// Top level of the event flag group unit: group and waiter tables and the
// sequencer that walks the waiter slots. Depends on efg_pkg.
//
// Usage: one input channel (in_valid_i/in_ready_o) carries an RTOS call
// (create, pend, post, cancel); one output channel (out_valid_o/out_ready_i)
// returns one or more result transactions, the final one flagged by last_o.
// Create, pend and cancel produce one result: the transaction is accepted,
// the decision is taken in the next cycle and the result is held in the
// output register from the following cycle on. A post scans all 16 waiter
// slots with one shared condition checker, one slot a cycle, stopping to
// emit a woken transaction for each waiter it releases, and ends with a
// summary transaction carrying the group flags after all consumes. The
// unit takes one call at a time: in_ready_o is high only while idle.
// When the receiver stalls, the current result holds and the scan pauses.
// Reset empties the pool, clears all group flags and marks every waiter
// slot inactive; waiter records need no clearing since they are read
// only while their slot is active.
module event_flag_group_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       mode_i,
  input  logic [efg_pkg::GW-1:0]           group_i,
  input  logic [efg_pkg::FLAG_BITS-1:0]    pattern_i,
  input  logic [1:0]                       wait_kind_i,
  input  logic                             consume_i,
  input  logic                             post_op_i,
  input  logic [efg_pkg::WW-1:0]           waiter_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       status_o,
  output logic [efg_pkg::GW-1:0]           result_group_o,
  output logic [efg_pkg::WW-1:0]           result_waiter_o,
  output logic [efg_pkg::FLAG_BITS-1:0]    flags_o,
  output logic                             last_o
);
  import efg_pkg::*;

  state_e state_q, state_d;

  logic [FLAG_BITS-1:0] gflags_q [GROUPS];
  logic [GROUPS-1:0]    glive_q;
  logic [GW:0]          galloc_q;
  logic [WAITERS-1:0]   wact_q;
  logic [GW-1:0]        wgrp_q  [WAITERS];
  logic [FLAG_BITS-1:0] wbits_q [WAITERS];
  logic [1:0]           wkind_q [WAITERS];
  logic                 wcons_q [WAITERS];

  // Captured call.
  logic [1:0]           mode_q;
  logic [GW-1:0]        grp_q;
  logic [FLAG_BITS-1:0] pat_q;
  logic [1:0]           kind_q;
  logic                 cons_q;
  logic [WW-1:0]        wid_q;

  // Scan state of a post.
  logic [WW:0]          idx_q, idx_d;
  logic [FLAG_BITS-1:0] cur_q, cur_d;   // flags the waiters are tested against
  logic [FLAG_BITS-1:0] acc_q, acc_d;   // flags with consumes applied

  logic [2:0]           ost_q, ost_d;
  logic [GW-1:0]        ogrp_q, ogrp_d;
  logic [WW-1:0]        owt_q, owt_d;
  logic [FLAG_BITS-1:0] ofl_q, ofl_d;
  logic                 olast_q, olast_d;

  logic                 in_acc, out_acc;
  logic [WW-1:0]        slot;
  logic [FLAG_BITS-1:0] s_rdy;
  logic                 s_hit;
  logic [FLAG_BITS-1:0] p_rdy;
  logic                 p_met;

  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP) || (state_q == S_WAKE) || (state_q == S_FINAL);

  assign slot  = idx_q[WW-1:0];
  // One checker tests the scan slot during a post; a separate one tests the pend call.
  assign s_rdy = ready_bits(cur_q, wbits_q[slot], wkind_q[slot]);
  assign s_hit = !idx_q[WW] && wact_q[slot] && (wgrp_q[slot] == grp_q) &&
                 cond_met(wbits_q[slot], s_rdy, wkind_q[slot]);
  assign p_rdy = ready_bits(gflags_q[grp_q], pat_q, kind_q);
  assign p_met = cond_met(pat_q, p_rdy, kind_q);

  assign status_o        = ost_q;
  assign result_group_o  = ogrp_q;
  assign result_waiter_o = owt_q;
  assign flags_o         = ofl_q;
  assign last_o          = olast_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    acc_d   = acc_q;
    unique case (state_q)
      S_IDLE: if (in_acc) begin
        state_d = S_SCAN;
        idx_d   = '0;
        cur_d   = post_op_i ? (gflags_q[group_i] & ~pattern_i) :
                              (gflags_q[group_i] | pattern_i);
        acc_d   = cur_d;
      end
      S_SCAN: begin
        if (mode_q != MODE_POST) begin
          state_d = S_RESP;
        end else if (idx_q[WW]) begin
          state_d = S_FINAL;
        end else if (s_hit) begin
          state_d = S_WAKE;
          if (wcons_q[slot]) acc_d = consume_bits(acc_q, s_rdy, wkind_q[slot]);
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_WAKE: if (out_acc) begin
        state_d = S_SCAN;
        idx_d   = idx_q + 1'b1;
      end
      S_FINAL, S_RESP: if (out_acc) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Result of the current scan step, loaded into the output register.
  always_comb begin
    ost_d   = ST_OK;
    ogrp_d  = grp_q;
    owt_d   = wid_q;
    ofl_d   = '0;
    olast_d = 1'b1;
    unique case (mode_q)
      MODE_CREATE: begin
        owt_d = '0;
        if (galloc_q[GW]) begin
          ost_d  = ST_POOL;
          ogrp_d = '0;
        end else begin
          ogrp_d = galloc_q[GW-1:0];
        end
      end
      MODE_PEND: begin
        if (!glive_q[grp_q])    ost_d = ST_NOT_LIVE;
        else if (wact_q[wid_q]) ost_d = ST_BAD_WAIT;
        else if (p_met)         ofl_d = p_rdy;
        else                    ost_d = ST_PARKED;
      end
      MODE_POST: begin
        owt_d = '0;
        if (!glive_q[grp_q]) begin
          ost_d = ST_NOT_LIVE;
        end else if (idx_q[WW]) begin
          ofl_d = acc_q;
        end else if (s_hit) begin
          ost_d   = ST_WOKEN;
          owt_d   = slot;
          ofl_d   = s_rdy;
          olast_d = 1'b0;
        end
      end
      MODE_CANCEL: begin
        if (wact_q[wid_q]) begin
          ost_d  = ST_CANCELLED;
          ogrp_d = wgrp_q[wid_q];
        end else begin
          ost_d  = ST_BAD_WAIT;
          ogrp_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      glive_q  <= '0;
      galloc_q <= '0;
      wact_q   <= '0;
      for (int i = 0; i < GROUPS; i++) gflags_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && in_acc && mode_i == MODE_POST && glive_q[group_i]) begin
        // Post update happens at accept; the scan reads the new value.
        if (post_op_i) gflags_q[group_i] <= gflags_q[group_i] & ~pattern_i;
        else           gflags_q[group_i] <= gflags_q[group_i] | pattern_i;
      end
      if (state_q == S_SCAN) begin
        unique case (mode_q)
          MODE_CREATE: if (!galloc_q[GW]) begin
            gflags_q[galloc_q[GW-1:0]] <= pat_q;
            glive_q[galloc_q[GW-1:0]]  <= 1'b1;
            galloc_q <= galloc_q + 1'b1;
          end
          MODE_PEND: if (glive_q[grp_q] && !wact_q[wid_q]) begin
            if (p_met) begin
              if (cons_q) gflags_q[grp_q] <= consume_bits(gflags_q[grp_q], p_rdy, kind_q);
            end else begin
              wact_q[wid_q] <= 1'b1;
            end
          end
          MODE_POST: begin
            if (s_hit) wact_q[slot] <= 1'b0;
            if (idx_q[WW] && glive_q[grp_q]) gflags_q[grp_q] <= acc_q;
          end
          MODE_CANCEL: if (wact_q[wid_q]) wact_q[wid_q] <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cur_q <= cur_d;
    acc_q <= acc_d;
    if (in_acc) begin
      mode_q <= mode_i;
      grp_q  <= group_i;
      pat_q  <= pattern_i;
      kind_q <= wait_kind_i;
      cons_q <= consume_i;
      wid_q  <= waiter_i;
    end
    if (state_q == S_SCAN && mode_q == MODE_PEND && glive_q[grp_q] && !wact_q[wid_q] &&
        !p_met) begin
      wgrp_q[wid_q]  <= grp_q;
      wbits_q[wid_q] <= pat_q;
      wkind_q[wid_q] <= kind_q;
      wcons_q[wid_q] <= cons_q;
    end
    if (state_q == S_SCAN) begin
      ost_q   <= ost_d;
      ogrp_q  <= ogrp_d;
      owt_q   <= owt_d;
      ofl_q   <= ofl_d;
      olast_q <= olast_d;
    end
  end

endmodule
